// ----- hw/rtl/gfle_pkg.sv -----
// Shared types, constants and field arithmetic for the GF(2^m) log/antilog engine.
`timescale 1ns / 1ps

package gfle_pkg;

  // Field sizing
  localparam int MaxDegree  = 8;
  localparam int ElemW      = 8;
  localparam int PolyW      = ElemW + 1;
  localparam int DegW       = 4;
  localparam int TableDepth = 256;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int StatusW    = 3;
  localparam int CmdW       = 2;
  localparam int CfgIdxW    = 1;

  // Reset values of the configuration registers
  localparam logic [PolyW-1:0] PolyReset = PolyW'(285);
  localparam logic [ElemW-1:0] GenReset  = ElemW'(2);

  typedef enum logic [CmdW-1:0] {
    CMD_BUILD     = 2'd0,
    CMD_MUL       = 2'd1,
    CMD_READ_LOG  = 2'd2,
    CMD_READ_ALOG = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK            = 3'd0,
    STAT_BAD_DEGREE    = 3'd1,
    STAT_GEN_OUTSIDE   = 3'd2,
    STAT_NOT_PRIMITIVE = 3'd3,
    STAT_OPERAND_RANGE = 3'd4,
    STAT_NOT_READY     = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLY = 1'b0,
    CFG_GEN  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [ElemW-1:0] operand_a;
    logic [ElemW-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [ElemW-1:0]   value;
    logic [StatusW-1:0] status;
  } out_item_t;

  // Table access request from the controller to the table memories
  typedef struct packed {
    logic             log_we;
    logic [AddrW-1:0] log_waddr;
    logic [ElemW-1:0] log_wdata;
    logic             alog_we;
    logic [AddrW-1:0] alog_waddr;
    logic [ElemW-1:0] alog_wdata;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
  } tbl_req_t;

  // Position of the highest set bit of the polynomial (the field degree m)
  function automatic logic [DegW-1:0] poly_degree(input logic [PolyW-1:0] poly);
    logic [DegW-1:0] d;
    d = '0;
    for (int k = 0; k < PolyW; k++) begin
      if (poly[k]) begin
        d = DegW'(k);
      end
    end
    return d;
  endfunction

  // Carry-less shift-and-add product of x and y, reduced by poly of degree deg
  function automatic logic [ElemW-1:0] gf_mul(input logic [ElemW-1:0] x,
                                              input logic [ElemW-1:0] y,
                                              input logic [PolyW-1:0] poly,
                                              input logic [DegW-1:0]  deg);
    logic [ElemW-1:0] acc;
    logic [ElemW-1:0] yy;
    logic [PolyW-1:0] sh;
    acc = '0;
    yy  = y;
    for (int k = 0; k < ElemW; k++) begin
      if (x[k]) begin
        acc = acc ^ yy;
      end
      sh = {yy, 1'b0};
      if (sh[deg]) begin
        sh = sh ^ poly;
      end
      yy = sh[ElemW-1:0];
    end
    return acc;
  endfunction

endpackage

// ----- hw/rtl/gfle_tables.sv -----
// Log and antilog table memories: one write port each, shared read address, registered read data.
`timescale 1ns / 1ps

module gfle_tables (
  input  logic                     clk_i,
  input  gfle_pkg::tbl_req_t       tbl_req_i,
  output logic [gfle_pkg::ElemW-1:0] log_rdata_o,
  output logic [gfle_pkg::ElemW-1:0] alog_rdata_o
);
  import gfle_pkg::*;

  logic [ElemW-1:0] log_mem  [TableDepth];
  logic [ElemW-1:0] alog_mem [TableDepth];
  logic [ElemW-1:0] log_rdata_q;
  logic [ElemW-1:0] alog_rdata_q;

  // log table: element -> exponent
  always_ff @(posedge clk_i) begin
    if (tbl_req_i.log_we) begin
      log_mem[tbl_req_i.log_waddr] <= tbl_req_i.log_wdata;
    end
    if (tbl_req_i.rd_en) begin
      log_rdata_q <= log_mem[tbl_req_i.rd_addr];
    end
  end

  // antilog table: exponent -> element
  always_ff @(posedge clk_i) begin
    if (tbl_req_i.alog_we) begin
      alog_mem[tbl_req_i.alog_waddr] <= tbl_req_i.alog_wdata;
    end
    if (tbl_req_i.rd_en) begin
      alog_rdata_q <= alog_mem[tbl_req_i.rd_addr];
    end
  end

  assign log_rdata_o  = log_rdata_q;
  assign alog_rdata_o = alog_rdata_q;

endmodule

// ----- hw/rtl/gfle_ctrl.sv -----
// Command sequencer: config registers, range checks, multiply, table walk, output register.
`timescale 1ns / 1ps

module gfle_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gfle_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gfle_pkg::PolyW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  gfle_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output gfle_pkg::out_item_t          out_item_o,
  output gfle_pkg::tbl_req_t           tbl_req_o,
  input  logic [gfle_pkg::ElemW-1:0]   log_rdata_i,
  input  logic [gfle_pkg::ElemW-1:0]   alog_rdata_i
);
  import gfle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_ZERO = 4'b0100,
    S_WALK = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [PolyW-1:0] poly_q, poly_d;
  logic [ElemW-1:0] gen_q, gen_d;
  logic [DegW-1:0]  field_degree_q, field_degree_d;
  logic             ready_q, ready_d;
  logic [DegW-1:0]  m_q, m_d;
  logic [ElemW-1:0] order_q, order_d;
  logic [ElemW-1:0] x_q, x_d;
  logic [ElemW-1:0] i_q, i_d;
  logic [CmdW-1:0]  cmd_q, cmd_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  logic             in_fire;
  logic             out_load;
  logic [DegW-1:0]  pdeg;
  logic [PolyW-1:0] alog_limit;
  logic [ElemW-1:0] x_next;
  logic [ElemW-1:0] i_inc;
  logic [ElemW-1:0] mul_res;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;

  // Datapath helpers
  assign pdeg       = poly_degree(poly_q);
  assign alog_limit = (PolyW'(1) << field_degree_q) - PolyW'(1);
  assign x_next     = gf_mul(x_q, gen_q, poly_q, m_q);
  assign i_inc      = i_q + ElemW'(1);
  assign mul_res    = gf_mul(in_item_i.operand_a, in_item_i.operand_b, poly_q, field_degree_q);

  // Sequencer
  always_comb begin
    state_d        = state_q;
    poly_d         = poly_q;
    gen_d          = gen_q;
    field_degree_d = field_degree_q;
    ready_d        = ready_q;
    m_d            = m_q;
    order_d        = order_q;
    x_d            = x_q;
    i_d            = i_q;
    cmd_d          = cmd_q;
    out_load       = 1'b0;
    out_item_d     = out_item_q;
    tbl_req_o      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d             = in_item_i.cmd;
          out_item_d.value  = '0;
          out_item_d.status = STAT_OK;
          if (in_item_i.cmd == CMD_BUILD) begin
            ready_d = 1'b0;
            if (poly_q[PolyW-1:1] == '0 || pdeg > DegW'(MaxDegree)) begin
              out_load          = 1'b1;
              out_item_d.status = STAT_BAD_DEGREE;
            end else if ((gen_q >> pdeg) != '0) begin
              out_load          = 1'b1;
              out_item_d.status = STAT_GEN_OUTSIDE;
            end else begin
              m_d     = pdeg;
              order_d = ElemW'((PolyW'(1) << pdeg) - PolyW'(1));
              x_d     = ElemW'(1);
              i_d     = '0;
              state_d = S_ZERO;
            end
          end else if (!ready_q || field_degree_q == '0 ||
                       field_degree_q > DegW'(MaxDegree)) begin
            out_load          = 1'b1;
            out_item_d.status = STAT_NOT_READY;
          end else if (in_item_i.cmd == CMD_MUL) begin
            out_load = 1'b1;
            if ((in_item_i.operand_a >> field_degree_q) != '0 ||
                (in_item_i.operand_b >> field_degree_q) != '0) begin
              out_item_d.status = STAT_OPERAND_RANGE;
            end else begin
              out_item_d.value = mul_res;
            end
          end else if (in_item_i.cmd == CMD_READ_LOG) begin
            if ((in_item_i.operand_a >> field_degree_q) != '0) begin
              out_load          = 1'b1;
              out_item_d.status = STAT_OPERAND_RANGE;
            end else begin
              tbl_req_o.rd_en   = 1'b1;
              tbl_req_o.rd_addr = in_item_i.operand_a;
              state_d           = S_READ;
            end
          end else begin
            if ({1'b0, in_item_i.operand_a} >= alog_limit) begin
              out_load          = 1'b1;
              out_item_d.status = STAT_OPERAND_RANGE;
            end else begin
              tbl_req_o.rd_en   = 1'b1;
              tbl_req_o.rd_addr = in_item_i.operand_a;
              state_d           = S_READ;
            end
          end
        end
      end
      S_READ: begin
        out_load          = 1'b1;
        out_item_d.status = STAT_OK;
        out_item_d.value  = (cmd_q == CMD_READ_LOG) ? log_rdata_i : alog_rdata_i;
        state_d           = S_IDLE;
      end
      S_ZERO: begin
        // log of zero is defined as zero
        tbl_req_o.log_we    = 1'b1;
        tbl_req_o.log_waddr = '0;
        tbl_req_o.log_wdata = '0;
        state_d             = S_WALK;
      end
      S_WALK: begin
        // one power of the generator per cycle
        tbl_req_o.alog_we    = 1'b1;
        tbl_req_o.alog_waddr = i_q;
        tbl_req_o.alog_wdata = x_q;
        tbl_req_o.log_we     = 1'b1;
        tbl_req_o.log_waddr  = x_q;
        tbl_req_o.log_wdata  = i_q;
        x_d                  = x_next;
        i_d                  = i_inc;
        if (x_next == ElemW'(1) || i_inc == order_q) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (x_next == ElemW'(1) && i_inc == order_q) begin
            out_item_d.status = STAT_OK;
            out_item_d.value  = ElemW'(m_q);
            field_degree_d    = m_q;
            ready_d           = 1'b1;
          end else begin
            out_item_d.status = STAT_NOT_PRIMITIVE;
            out_item_d.value  = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Config writes drop the ready flag
    if (cfg_we_i) begin
      ready_d = 1'b0;
      case (cfg_index_i)
        CFG_POLY: poly_d = cfg_wdata_i;
        CFG_GEN:  gen_d  = cfg_wdata_i[ElemW-1:0];
        default:  ;
      endcase
    end
  end

  // Output register frees when taken; loads only when free or being freed
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      poly_q         <= PolyReset;
      gen_q          <= GenReset;
      field_degree_q <= '0;
      ready_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      poly_q         <= poly_d;
      gen_q          <= gen_d;
      field_degree_q <= field_degree_d;
      ready_q        <= ready_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    m_q        <= m_d;
    order_q    <= order_d;
    x_q        <= x_d;
    i_q        <= i_d;
    cmd_q      <= cmd_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- hw/rtl/gf2m_log_exp_table_engine_top.sv -----
// Multiply, product, range and ready errors: result registered in the cycle after accept.
// Log/antilog read: the table read data register, then the output register. Build: the
// log-of-zero write, then the walk, one log and one antilog entry per step. One item is
// in work at a time; the next item can be taken in the cycle the previous result shows,
// unless it is stalled. Reset (async, active low) clears control state and restores the
// register defaults; table contents are undefined until a build completes.
`timescale 1ns / 1ps

module gf2m_log_exp_table_engine_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gfle_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gfle_pkg::PolyW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  gfle_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output gfle_pkg::out_item_t          out_item_o
);
  import gfle_pkg::*;

  tbl_req_t         tbl_req;
  logic [ElemW-1:0] log_rdata;
  logic [ElemW-1:0] alog_rdata;

  // Sequencer and datapath
  gfle_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o),
    .tbl_req_o    (tbl_req),
    .log_rdata_i  (log_rdata),
    .alog_rdata_i (alog_rdata)
  );

  // Table memories
  gfle_tables u_tables (
    .clk_i        (clk_i),
    .tbl_req_i    (tbl_req),
    .log_rdata_o  (log_rdata),
    .alog_rdata_o (alog_rdata)
  );

endmodule

// ----- hw/rtl/gfle_checker.sv -----
// Port-level checks for the GF(2^m) engine, bound to the top level.
`timescale 1ns / 1ps

module gfle_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input gfle_pkg::out_item_t out_item_o
);
  import gfle_pkg::*;

  // A result waiting on a stalled consumer stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != STAT_OK |-> out_item_o.value == '0)
    else $error("nonzero value with error status");

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status <= STAT_NOT_READY)
    else $error("undefined status code");

  // An accepted item either holds off input or shows a result next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o || out_valid_o)
    else $error("accepted item made no progress");

endmodule

bind gf2m_log_exp_table_engine_top gfle_checker u_gfle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
